### rtl/core/button_multi_click_detector_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the button multi-click detector
// Shared implication checks, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_MULTI_CLICK_DETECTOR_UNIT_MACROS_SVH
`define BUTTON_MULTI_CLICK_DETECTOR_UNIT_MACROS_SVH

// same-cycle implication
`define BMCD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmcd check failed: same-cycle implication");

// next-cycle implication
`define BMCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmcd check failed: next-cycle implication");

`endif

### rtl/core/bmcd_pkg.sv
// ----------------------------------------------------------------------------
// bmcd_pkg
// Types, widths and codes for the button multi-click detector.
// ----------------------------------------------------------------------------
package bmcd_pkg;

    localparam int COUNT_W   = 16;
    localparam int PRESS_W   = 3;
    localparam int EVENT_W   = 3;
    localparam int PHASE_W   = 2;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [PRESS_W-1:0] PRESS_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_MIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_MAX  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE     = 2'd3;

    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd100;
    localparam logic [CFG_W-1:0] CLICK_MIN_RST  = 16'd2;
    localparam logic [CFG_W-1:0] CLICK_MAX_RST  = 16'd30;
    localparam logic [CFG_W-1:0] SETTLE_RST     = 16'd30;

    localparam logic [EVENT_W-1:0] EV_NONE   = 3'd0;
    localparam logic [EVENT_W-1:0] EV_SINGLE = 3'd1;
    localparam logic [EVENT_W-1:0] EV_DOUBLE = 3'd2;
    localparam logic [EVENT_W-1:0] EV_TRIPLE = 3'd3;
    localparam logic [EVENT_W-1:0] EV_LONG   = 3'd4;

    localparam logic [PHASE_W-1:0] PHC_IDLE    = 2'd0;
    localparam logic [PHASE_W-1:0] PHC_DOWN    = 2'd1;
    localparam logic [PHASE_W-1:0] PHC_PRESSED = 2'd2;
    localparam logic [PHASE_W-1:0] PHC_UP      = 2'd3;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [PRESS_W-1:0] press_t;
    typedef logic [EVENT_W-1:0] event_t;
    typedef logic [PHASE_W-1:0] phase_code_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_DOWN    = 4'b0010,
        PH_PRESSED = 4'b0100,
        PH_UP      = 4'b1000
    } phase_t;

    function automatic phase_code_t phase_code(input phase_t ph);
        phase_code_t code;
        case (ph)
            PH_IDLE:    code = PHC_IDLE;
            PH_DOWN:    code = PHC_DOWN;
            PH_PRESSED: code = PHC_PRESSED;
            PH_UP:      code = PHC_UP;
            default:    code = PHC_IDLE;
        endcase
        return code;
    endfunction

    function automatic count_t sat_inc(input count_t v);
        return (v == '1) ? v : v + COUNT_W'(1);
    endfunction

endpackage

### rtl/core/bmcd_if.sv
// ----------------------------------------------------------------------------
// bmcd channel interfaces
// Valid/ready channels for pin samples and detector results.
// ----------------------------------------------------------------------------
interface bmcd_sample_if;
    logic valid;
    logic ready;
    logic pin_level;

    modport source (output valid, output pin_level, input ready);
    modport sink   (input valid, input pin_level, output ready);
endinterface

interface bmcd_result_if;
    logic                       valid;
    logic                       ready;
    logic [bmcd_pkg::EVENT_W-1:0] click_event;
    logic [bmcd_pkg::PHASE_W-1:0] key_phase_now;

    modport source (output valid, output click_event, output key_phase_now, input ready);
    modport sink   (input valid, input click_event, input key_phase_now, output ready);
endinterface

### rtl/core/button_multi_click_detector_unit.sv
// ----------------------------------------------------------------------------
// button_multi_click_detector_unit: click, multi-click and long-press detector
// Result path: input register, then phase/counter update into result reg.
// Throughput 1 item per cycle unless the result channel stalls (result.ready low).
// Async active-low reset: idle phase, counters zero, config registers at defaults.
// ----------------------------------------------------------------------------
`include "button_multi_click_detector_unit_macros.svh"

module button_multi_click_detector_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [bmcd_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [bmcd_pkg::CFG_W-1:0]     cfg_wdata,
    bmcd_sample_if.sink                    sample,
    bmcd_result_if.source                  result
);

    bmcd_pkg::count_t long_press_reg;
    bmcd_pkg::count_t click_min_reg;
    bmcd_pkg::count_t click_max_reg;
    bmcd_pkg::count_t settle_reg;

    logic s1_valid_reg;
    logic pin_reg;
    logic s1_adv;
    logic out_valid_reg;

    bmcd_pkg::phase_t phase_reg, phase_next;
    bmcd_pkg::press_t press_count_reg, press_count_next;
    logic             release_seen_reg, release_seen_next;
    bmcd_pkg::count_t hold_ticks_reg, hold_ticks_next;
    bmcd_pkg::count_t high_ticks_reg, high_ticks_next;
    bmcd_pkg::count_t high_inc;
    bmcd_pkg::event_t event_reg, event_next;
    bmcd_pkg::phase_code_t phase_code_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg <= bmcd_pkg::LONG_PRESS_RST;
            click_min_reg  <= bmcd_pkg::CLICK_MIN_RST;
            click_max_reg  <= bmcd_pkg::CLICK_MAX_RST;
            settle_reg     <= bmcd_pkg::SETTLE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                bmcd_pkg::CFG_LONG_PRESS: long_press_reg <= cfg_wdata;
                bmcd_pkg::CFG_CLICK_MIN:  click_min_reg  <= cfg_wdata;
                bmcd_pkg::CFG_CLICK_MAX:  click_max_reg  <= cfg_wdata;
                bmcd_pkg::CFG_SETTLE:     settle_reg     <= cfg_wdata;
                default:                  ;
            endcase
        end
    end

    // handshake
    assign s1_adv       = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || s1_adv;
    assign result.valid = out_valid_reg;
    assign result.click_event   = event_reg;
    assign result.key_phase_now = phase_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.ready)
            begin
                s1_valid_reg <= sample.valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            pin_reg <= sample.pin_level;
        end
        if (s1_adv)
        begin
            event_reg      <= event_next;
            phase_code_reg <= bmcd_pkg::phase_code(phase_next);
        end
    end

    // phase machine and judgment
    assign high_inc = release_seen_reg ? bmcd_pkg::sat_inc(high_ticks_reg) : high_ticks_reg;

    always_comb
    begin
        phase_next        = phase_reg;
        press_count_next  = press_count_reg;
        release_seen_next = release_seen_reg;
        hold_ticks_next   = hold_ticks_reg;
        high_ticks_next   = high_ticks_reg;
        event_next        = bmcd_pkg::EV_NONE;
        case (phase_reg)
            bmcd_pkg::PH_IDLE:
            begin
                if (!pin_reg)
                begin
                    if (press_count_reg != bmcd_pkg::PRESS_MAX)
                    begin
                        press_count_next = press_count_reg + bmcd_pkg::PRESS_W'(1);
                    end
                    release_seen_next = 1'b0;
                    hold_ticks_next   = '0;
                    phase_next        = bmcd_pkg::PH_DOWN;
                end
                else
                begin
                    high_ticks_next = high_inc;
                    if (hold_ticks_reg > long_press_reg)
                    begin
                        event_next        = bmcd_pkg::EV_LONG;
                        press_count_next  = '0;
                        release_seen_next = 1'b0;
                        hold_ticks_next   = '0;
                        high_ticks_next   = '0;
                    end
                    else if (hold_ticks_reg > click_max_reg && hold_ticks_reg < long_press_reg)
                    begin
                        press_count_next  = '0;
                        release_seen_next = 1'b0;
                        hold_ticks_next   = '0;
                        high_ticks_next   = '0;
                    end
                    else if (high_inc > settle_reg && hold_ticks_reg > click_min_reg
                             && hold_ticks_reg < click_max_reg)
                    begin
                        if (press_count_reg inside {bmcd_pkg::EV_SINGLE, bmcd_pkg::EV_DOUBLE,
                                                    bmcd_pkg::EV_TRIPLE})
                        begin
                            event_next = bmcd_pkg::EVENT_W'(press_count_reg);
                        end
                        press_count_next  = '0;
                        release_seen_next = 1'b0;
                        hold_ticks_next   = '0;
                        high_ticks_next   = '0;
                    end
                end
            end
            bmcd_pkg::PH_DOWN:
            begin
                phase_next = bmcd_pkg::PH_PRESSED;
            end
            bmcd_pkg::PH_PRESSED:
            begin
                if (pin_reg)
                begin
                    release_seen_next = 1'b1;
                    high_ticks_next   = '0;
                    if (hold_ticks_reg > long_press_reg && press_count_reg != '0)
                    begin
                        press_count_next = press_count_reg - bmcd_pkg::PRESS_W'(1);
                    end
                    phase_next = bmcd_pkg::PH_UP;
                end
                else
                begin
                    hold_ticks_next = bmcd_pkg::sat_inc(hold_ticks_reg);
                end
            end
            default:
            begin
                phase_next = bmcd_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= bmcd_pkg::PH_IDLE;
            press_count_reg  <= '0;
            release_seen_reg <= 1'b0;
            hold_ticks_reg   <= '0;
            high_ticks_reg   <= '0;
        end
        else if (s1_adv)
        begin
            phase_reg        <= phase_next;
            press_count_reg  <= press_count_next;
            release_seen_reg <= release_seen_next;
            hold_ticks_reg   <= hold_ticks_next;
            high_ticks_reg   <= high_ticks_next;
        end
    end

    // checks
    `BMCD_ASSERT_SAME(a_long_only_idle, clk, rst_n, result.valid && result.click_event == bmcd_pkg::EV_LONG, result.key_phase_now == bmcd_pkg::PHC_IDLE)
    `BMCD_ASSERT_NEXT(a_event_clears, clk, rst_n, s1_adv && event_next != bmcd_pkg::EV_NONE, press_count_reg == '0 && hold_ticks_reg == '0 && high_ticks_reg == '0)
    `BMCD_ASSERT_NEXT(a_down_to_pressed, clk, rst_n, s1_adv && phase_reg == bmcd_pkg::PH_DOWN, phase_reg == bmcd_pkg::PH_PRESSED)

endmodule
